FILE: design/smavg_pkg.sv
// Shared types and constants for the six-axis moving average core.
// Sample widths, stream packing, temperature scaling and the lane control bundle.
// No dependencies.
package smavg_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int NUM_AXES         = 6;
    localparam int TEMP_W           = 9;
    localparam int FILTER_DEPTH_DEF = 4;

    // 7 x 16 input bits; 6 x 16 + 9 output bits, padded to 14 bytes
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 112;
    localparam int TEMP_LSB  = NUM_AXES * SAMPLE_W;

    localparam int TEMP_OFFSET  = 12590;
    localparam int TEMP_DIVISOR = 340;
    localparam int TEMP_X_W     = SAMPLE_W + 1;
    localparam int TEMP_SHIFT   = TEMP_X_W + $clog2(TEMP_DIVISOR);
    localparam int TEMP_PROD_W  = TEMP_X_W + TEMP_SHIFT + 1;
    localparam logic [TEMP_SHIFT:0] TEMP_MAGIC = (TEMP_SHIFT + 1)'(
        ((64'd1 << TEMP_SHIFT) + 64'(TEMP_DIVISOR) - 64'd1) / 64'(TEMP_DIVISOR));

    typedef struct packed {
        logic load;     // request accepted: update rings and stage 1
        logic adv1;     // stage 1 -> stage 2
        logic adv2;     // stage 2 -> output register
        logic adv_out;  // output register may change
    } t_lane_ctrl;

endpackage

FILE: design/smavg_axis_lane.sv
// One axis channel: history shift line, running sum and reciprocal divide.
// Depends on smavg_pkg.
module smavg_axis_lane #(
    parameter int FILTER_DEPTH = smavg_pkg::FILTER_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smavg_pkg::t_lane_ctrl                i_ctrl,
    input  logic signed [smavg_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [smavg_pkg::SAMPLE_W-1:0] o_avg
);
    import smavg_pkg::*;

    localparam int SUM_W     = SAMPLE_W + $clog2(FILTER_DEPTH) + 1;
    localparam int DIV_SHIFT = SUM_W + $clog2(FILTER_DEPTH);
    localparam int PROD_W    = SUM_W + DIV_SHIFT + 1;
    localparam logic [DIV_SHIFT:0] DIV_MAGIC = (DIV_SHIFT + 1)'(
        ((64'd1 << DIV_SHIFT) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));

    logic signed [SAMPLE_W-1:0] r_taps [FILTER_DEPTH];
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic                       r_neg;
    logic [PROD_W-1:0]          r_prod;
    logic [SUM_W-1:0]           w_mag;
    logic [PROD_W-1:0]          w_prod;
    logic [SUM_W-1:0]           w_quot;
    logic [SUM_W-1:0]           w_signed_quot;

    // add the newest sample, drop the oldest
    always_comb begin
        n_sum = r_sum
              + {{(SUM_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample}
              - {{(SUM_W-SAMPLE_W){r_taps[FILTER_DEPTH-1][SAMPLE_W-1]}},
                 r_taps[FILTER_DEPTH-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FILTER_DEPTH; i++) begin
                r_taps[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_ctrl.load) begin
            r_taps[0] <= i_sample;
            for (int i = 1; i < FILTER_DEPTH; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
            r_sum <= n_sum;
        end
    end

    assign w_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_prod = PROD_W'(w_mag) * PROD_W'(DIV_MAGIC);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv1) begin
            r_neg  <= r_sum[SUM_W-1];
            r_prod <= w_prod;
        end
    end

    // truncate toward zero: divide the magnitude, restore the sign
    assign w_quot        = SUM_W'(r_prod >> DIV_SHIFT);
    assign w_signed_quot = r_neg ? (~w_quot + 1'b1) : w_quot;
    assign o_avg         = w_signed_quot[SAMPLE_W-1:0];

endmodule

FILE: design/smavg_temp_lane.sv
// Temperature channel: offset, then divide by the scale factor via reciprocal.
// Depends on smavg_pkg.
module smavg_temp_lane (
    input  logic                                 i_clk,
    input  smavg_pkg::t_lane_ctrl                i_ctrl,
    input  logic signed [smavg_pkg::SAMPLE_W-1:0] i_temp_raw,
    output logic signed [smavg_pkg::TEMP_W-1:0]   o_temp_degrees
);
    import smavg_pkg::*;

    logic signed [TEMP_X_W-1:0] r_x;
    logic                       r_neg;
    logic [TEMP_PROD_W-1:0]     r_prod;
    logic [TEMP_X_W-1:0]        w_mag;
    logic [TEMP_PROD_W-1:0]     w_prod;
    logic [TEMP_X_W-1:0]        w_quot;
    logic [TEMP_X_W-1:0]        w_signed_quot;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= {i_temp_raw[SAMPLE_W-1], i_temp_raw} + TEMP_X_W'(TEMP_OFFSET);
        end
    end

    assign w_mag  = r_x[TEMP_X_W-1] ? TEMP_X_W'(-r_x) : TEMP_X_W'(r_x);
    assign w_prod = TEMP_PROD_W'(w_mag) * TEMP_PROD_W'(TEMP_MAGIC);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv1) begin
            r_neg  <= r_x[TEMP_X_W-1];
            r_prod <= w_prod;
        end
    end

    assign w_quot         = TEMP_X_W'(r_prod >> TEMP_SHIFT);
    assign w_signed_quot  = r_neg ? (~w_quot + 1'b1) : w_quot;
    assign o_temp_degrees = w_signed_quot[TEMP_W-1:0];

endmodule

FILE: design/smavg_merge.sv
// Output stage: gathers the lane results into one request and holds it.
// Depends on smavg_pkg.
module smavg_merge (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  smavg_pkg::t_lane_ctrl                         i_ctrl,
    input  logic [smavg_pkg::NUM_AXES-1:0][smavg_pkg::SAMPLE_W-1:0] i_avg,
    input  logic [smavg_pkg::TEMP_W-1:0]                  i_temp_degrees,
    output logic                                          o_tvalid,
    output logic [smavg_pkg::M_TDATA_W-1:0]               o_tdata
);
    import smavg_pkg::*;

    logic                 r_tvalid;
    logic [M_TDATA_W-1:0] r_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (i_ctrl.adv_out) begin
            r_tvalid <= i_ctrl.adv2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv2) begin
            r_tdata <= M_TDATA_W'({i_temp_degrees, i_avg});
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;

endmodule

FILE: design/six_axis_moving_average_core.sv
// Six-axis boxcar moving average with temperature scaling.
// Stage 1 sums, stage 2 products, output register; one request per cycle unless m_axis stalls.
// Six axis lanes keep running sums; each divide is one registered reciprocal multiply.
// Each stage moves on when the one after it is empty or moving, so input is taken
// while a result waits. Synchronous active-low reset clears rings, sums and valids.
module six_axis_moving_average_core #(
    parameter int FILTER_DEPTH = smavg_pkg::FILTER_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
    // temp_raw (16 bits each, from bit 0 up)
    input  logic [smavg_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // accel_x_avg, accel_y_avg, accel_z_avg, gyro_x_avg, gyro_y_avg, gyro_z_avg
    // (16 bits each), temp_degrees (9 bits), 7 zero bits (from bit 0 up)
    output logic [smavg_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import smavg_pkg::*;

    logic                                  r_v1;
    logic                                  r_v2;
    logic                                  w_ready_out;
    logic                                  w_en2;
    logic                                  w_en1;
    t_lane_ctrl                            w_ctrl;
    logic [NUM_AXES-1:0][SAMPLE_W-1:0]     w_avg;
    logic [TEMP_W-1:0]                     w_temp_degrees;

    assign w_ready_out = !m_axis_tvalid || m_axis_tready;
    assign w_en2       = !r_v2 || w_ready_out;
    assign w_en1       = !r_v1 || w_en2;

    assign s_axis_tready  = w_en1;
    assign w_ctrl.load    = s_axis_tvalid && w_en1;
    assign w_ctrl.adv1    = r_v1 && w_en2;
    assign w_ctrl.adv2    = r_v2 && w_ready_out;
    assign w_ctrl.adv_out = w_ready_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_ctrl.load;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        smavg_axis_lane #(
            .FILTER_DEPTH(FILTER_DEPTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_sample(s_axis_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .o_avg   (w_avg[g])
        );
    end

    smavg_temp_lane u_temp (
        .i_clk         (i_clk),
        .i_ctrl        (w_ctrl),
        .i_temp_raw    (s_axis_tdata[TEMP_LSB +: SAMPLE_W]),
        .o_temp_degrees(w_temp_degrees)
    );

    smavg_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_avg         (w_avg),
        .i_temp_degrees(w_temp_degrees),
        .o_tvalid      (m_axis_tvalid),
        .o_tdata       (m_axis_tdata)
    );

    // back-pressure only when every stage is full and the output is stalled
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with a free stage");

    // an accepted request reaches stage 2 on the next advance
    a_stage1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_en2) |=> r_v2)
        else $error("stage 1 request lost");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[TEMP_LSB +: TEMP_W]) >= -9'sd59
                        && $signed(m_axis_tdata[TEMP_LSB +: TEMP_W]) <= 9'sd133))
        else $error("temperature out of range");

endmodule
